// File: src/tmpw_pkg.sv
// Package for the tetrahedral mesh point walk: state encoding, operation,
// status, word-select and register codes, and fixed weight constants.
// No dependencies.
`timescale 1ns / 1ps

package tmpw_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD0,
    S_LD0,
    S_OPND,
    S_MUL,
    S_NEG,
    S_ACC,
    S_DIV0,
    S_DIV1,
    S_DIV,
    S_WSET,
    S_WNEXT,
    S_DECIDE,
    S_NB,
    S_EMIT
  } tmpw_state_e;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOCATE = 1'b1;

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_INSIDE = 2'd1;
  localparam logic [1:0] ST_LEFT   = 2'd2;
  localparam logic [1:0] ST_HOPS   = 2'd3;

  localparam logic [4:0] SEL_VOLUME    = 5'd0;
  localparam logic [4:0] SEL_COEF_LAST = 5'd16;
  localparam logic [4:0] SEL_NB_FIRST  = 5'd17;
  localparam logic [4:0] SEL_NB_LAST   = 5'd20;

  localparam logic REG_CELL_COUNT = 1'b0;
  localparam logic REG_HOP_LIMIT  = 1'b1;

  // weights are Q2.30
  localparam int WFRAC = 30;
  localparam logic signed [31:0] W_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

  // remainder / shifted divisor width: |sum| < 2*6*2^63, shifted by 30
  localparam int DIV_W = 98;

endpackage

// File: src/tetra_mesh_point_walk.sv
// Tetrahedral mesh point walk, top level: cell stores, walk sequencer,
// shared 32x32 multiplier and bit-serial divider. Uses tmpw_pkg, tmpw_ram.
`timescale 1ns / 1ps

// A load item writes one word of a cell at the accept edge, and its result
// then passes through the emit state into the output register. A locate
// item walks the mesh: the work for each visited cell (4 weights, plus the
// neighbour step) is set by the single shared 32x32 multiplier (4 partial
// products for each of the 12 coefficient*coordinate products, one
// coefficient read per term) and the one-bit-per-cycle divider (32 steps
// per weight). A weight whose sum is zero or whose quotient saturates skips
// the divider. One item is in work at a time; the next item is taken while
// a finished result waits at the output. The stores are not cleared: a cell
// must be fully loaded before a walk reads it.
module tetra_mesh_point_walk #(
  parameter int MAX_CELLS = 4096,
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [11:0] cell_index_i,
  input  logic [4:0]  word_select_i,
  input  logic [63:0] word_value_i,
  input  logic [63:0] pos_x_i,
  input  logic [63:0] pos_y_i,
  input  logic [63:0] pos_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [11:0] final_cell_o,
  output logic [31:0] weight_0_o,
  output logic [31:0] weight_1_o,
  output logic [31:0] weight_2_o,
  output logic [31:0] weight_3_o,
  output logic [7:0]  hop_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  import tmpw_pkg::*;

  localparam int CW = $clog2(MAX_CELLS);
  localparam int LW = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int NW = CW + 1;

  tmpw_state_e state_q, state_d;

  logic [12:0] cell_count_q;
  logic [7:0]  hop_limit_q;

  logic [11:0]   ci_q;
  logic [63:0]   px_q, py_q, pz_q;
  logic [CW-1:0] cell_q;
  logic [1:0]    vtx_q, term_q, part_q;
  logic [127:0]  sum_q, acc_q, mn_q;
  logic [66:0]   d_q;
  logic          vneg_q, psgn_q, wneg_q;
  logic [63:0]   ma_q, mb_q;
  logic [DIV_W-1:0] r_q, t_q;
  logic [31:0]   q_q;
  logic [4:0]    cnt_q;
  logic signed [31:0] w_q [4];
  logic [7:0]    hop_q;
  logic [1:0]    res_status_q;
  logic [11:0]   res_final_q;

  logic        out_valid_q;
  logic [1:0]  so_q;
  logic [11:0] fo_q;
  logic [31:0] wo_q [4];
  logic [7:0]  ho_q;

  // RAM ports
  logic            vol_we, vol_re, coef_we, coef_re, nb_we, nb_re;
  logic [CW-1:0]   vol_addr_w;
  logic [CW+3:0]   coef_waddr, coef_raddr;
  logic [CW+1:0]   nb_waddr, nb_raddr;
  logic [63:0]     vol_rd, coef_rd;
  logic [NW-1:0]   nb_wdata, nb_rd;
  logic [1:0]      coef_rterm;

  logic          in_acc, ld_ok, nb_none;
  logic [LW-1:0] lim;
  logic [7:0]    hl;
  logic [63:0]   pos_sel, pos_mag, coef_mag, vol_mag;
  logic [31:0]   a_half, b_half;
  logic [63:0]   prod;
  logic [127:0]  acc_add, prod_fl;
  logic          all_in;
  logic [1:0]    mi;
  logic          nb_end;

  assign in_acc      = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_count_q <= 13'd4096;
      hop_limit_q  <= 8'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CELL_COUNT: cell_count_q <= cfg_data_i;
        REG_HOP_LIMIT:  hop_limit_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign lim = (LW'(cell_count_q) < LW'(MAX_CELLS)) ? LW'(cell_count_q) : LW'(MAX_CELLS);
  assign hl  = (hop_limit_q == 8'd0) ? 8'd1 : hop_limit_q;

  // load decode, written straight at the accept edge
  assign ld_ok   = in_acc && (operation_i == OP_LOAD) &&
                   (LW'(cell_index_i) < LW'(MAX_CELLS));
  assign vol_we  = ld_ok && (word_select_i == SEL_VOLUME);
  assign coef_we = ld_ok && (word_select_i != SEL_VOLUME) &&
                   (word_select_i <= SEL_COEF_LAST);
  assign nb_we   = ld_ok && (word_select_i >= SEL_NB_FIRST) &&
                   (word_select_i <= SEL_NB_LAST);
  assign vol_addr_w = CW'(cell_index_i);
  assign coef_waddr = {CW'(cell_index_i), 4'(word_select_i - 5'd1)};
  assign nb_waddr   = {CW'(cell_index_i), 2'(word_select_i - SEL_NB_FIRST)};
  // any index past the store can never be in range, so it is kept as none
  assign nb_none    = word_value_i[63] || (word_value_i >= 64'(MAX_CELLS));
  assign nb_wdata   = {nb_none, CW'(word_value_i)};

  assign coef_raddr = {cell_q, vtx_q, coef_rterm};

  tmpw_ram #(.WIDTH(64), .DEPTH(MAX_CELLS)) u_vol_ram (
    .clk_i   (clk_i),
    .we_i    (vol_we),
    .waddr_i (vol_addr_w),
    .wdata_i (word_value_i),
    .re_i    (vol_re),
    .raddr_i (cell_q),
    .rdata_o (vol_rd)
  );

  tmpw_ram #(.WIDTH(64), .DEPTH(16 * MAX_CELLS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (word_value_i),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rd)
  );

  tmpw_ram #(.WIDTH(NW), .DEPTH(4 * MAX_CELLS)) u_nb_ram (
    .clk_i   (clk_i),
    .we_i    (nb_we),
    .waddr_i (nb_waddr),
    .wdata_i (nb_wdata),
    .re_i    (nb_re),
    .raddr_i (nb_raddr),
    .rdata_o (nb_rd)
  );

  // operand selection and the shared multiplier
  always_comb begin
    case (term_q)
      2'd1:    pos_sel = px_q;
      2'd2:    pos_sel = py_q;
      default: pos_sel = pz_q;
    endcase
  end

  assign pos_mag  = pos_sel[63] ? (~pos_sel + 64'd1) : pos_sel;
  assign coef_mag = coef_rd[63] ? (~coef_rd + 64'd1) : coef_rd;
  assign vol_mag  = vol_rd[63] ? (~vol_rd + 64'd1) : vol_rd;

  assign a_half  = part_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign b_half  = part_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign prod    = a_half * b_half;
  assign acc_add = {64'd0, prod} << {part_q[1] & part_q[0], part_q[1] ^ part_q[0], 5'd0};
  // floor from Q.2F to Q.F
  assign prod_fl = 128'($signed(acc_q) >>> FRAC_BITS);

  // inside test and most negative weight (lowest index on a tie)
  always_comb begin
    all_in = 1'b1;
    mi     = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (w_q[i] < 0 || w_q[i] > W_ONE) begin
        all_in = 1'b0;
      end
    end
    for (int i = 1; i < 4; i++) begin
      if (w_q[i] < w_q[mi]) begin
        mi = 2'(i);
      end
    end
  end

  assign nb_raddr = {cell_q, mi};
  assign nb_end   = nb_rd[NW-1] || (LW'(nb_rd[CW-1:0]) >= lim);

  // next state and RAM read control
  always_comb begin
    state_d    = state_q;
    vol_re     = 1'b0;
    coef_re    = 1'b0;
    nb_re      = 1'b0;
    coef_rterm = 2'd0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (operation_i == OP_LOCATE) ? S_START : S_EMIT;
        end
      end
      S_START: begin
        state_d = (LW'(ci_q) >= lim) ? S_EMIT : S_RD0;
      end
      S_RD0: begin
        vol_re  = 1'b1;
        coef_re = 1'b1;
        state_d = S_LD0;
      end
      S_LD0: begin
        coef_re    = 1'b1;
        coef_rterm = 2'd1;
        state_d    = S_OPND;
      end
      S_OPND: state_d = S_MUL;
      S_MUL: begin
        if (part_q == 2'd3) begin
          state_d = S_NEG;
        end
      end
      S_NEG: state_d = S_ACC;
      S_ACC: begin
        if (term_q == 2'd3) begin
          state_d = S_DIV0;
        end else begin
          coef_re    = 1'b1;
          coef_rterm = term_q + 2'd1;
          state_d    = S_OPND;
        end
      end
      S_DIV0: state_d = S_DIV1;
      S_DIV1: begin
        if (mn_q == 128'd0 || mn_q >= {60'd0, d_q, 1'b0}) begin
          state_d = S_WNEXT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_q == 5'd0) begin
          state_d = S_WSET;
        end
      end
      S_WSET: state_d = S_WNEXT;
      S_WNEXT: begin
        state_d = (vtx_q == 2'd3) ? S_DECIDE : S_RD0;
      end
      S_DECIDE: begin
        if (all_in) begin
          state_d = S_EMIT;
        end else begin
          nb_re   = 1'b1;
          state_d = S_NB;
        end
      end
      S_NB: begin
        state_d = (nb_end || hop_q >= hl) ? S_EMIT : S_RD0;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walk datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          ci_q         <= cell_index_i;
          px_q         <= pos_x_i;
          py_q         <= pos_y_i;
          pz_q         <= pos_z_i;
          hop_q        <= 8'd0;
          res_final_q  <= cell_index_i;
          res_status_q <= (operation_i == OP_LOAD) ? ST_LOAD : ST_LEFT;
          for (int i = 0; i < 4; i++) begin
            w_q[i] <= 32'sd0;
          end
        end
      end
      S_START: begin
        cell_q <= CW'(ci_q);
        vtx_q  <= 2'd0;
      end
      S_LD0: begin
        sum_q  <= {{64{coef_rd[63]}}, coef_rd};
        d_q    <= ({3'd0, vol_mag} << 2) + ({3'd0, vol_mag} << 1);
        vneg_q <= vol_rd[63];
        term_q <= 2'd1;
      end
      S_OPND: begin
        ma_q   <= coef_mag;
        mb_q   <= pos_mag;
        psgn_q <= coef_rd[63] ^ pos_sel[63];
        acc_q  <= 128'd0;
        part_q <= 2'd0;
      end
      S_MUL: begin
        acc_q  <= acc_q + acc_add;
        part_q <= part_q + 2'd1;
      end
      S_NEG: begin
        if (psgn_q) begin
          acc_q <= ~acc_q + 128'd1;
        end
      end
      S_ACC: begin
        // x and z terms subtract, y adds
        if (term_q == 2'd2) begin
          sum_q <= sum_q + prod_fl;
        end else begin
          sum_q <= sum_q - prod_fl;
        end
        term_q <= term_q + 2'd1;
      end
      S_DIV0: begin
        mn_q   <= sum_q[127] ? (~sum_q + 128'd1) : sum_q;
        wneg_q <= sum_q[127] ^ vneg_q;
      end
      S_DIV1: begin
        if (mn_q == 128'd0) begin
          w_q[vtx_q] <= 32'sd0;
        end else if (mn_q >= {60'd0, d_q, 1'b0}) begin
          w_q[vtx_q] <= wneg_q ? W_MIN : W_MAX;
        end else begin
          r_q   <= {mn_q[DIV_W-WFRAC-1:0], {WFRAC{1'b0}}};
          t_q   <= {d_q, 31'd0};
          q_q   <= 32'd0;
          cnt_q <= 5'd31;
        end
      end
      S_DIV: begin
        if (r_q >= t_q) begin
          r_q <= r_q - t_q;
          q_q <= {q_q[30:0], 1'b1};
        end else begin
          q_q <= {q_q[30:0], 1'b0};
        end
        t_q   <= t_q >> 1;
        cnt_q <= cnt_q - 5'd1;
      end
      S_WSET: begin
        w_q[vtx_q] <= wneg_q ? $signed(~q_q + 32'd1) : $signed(q_q);
      end
      S_WNEXT: begin
        vtx_q <= vtx_q + 2'd1;
      end
      S_DECIDE: begin
        hop_q       <= hop_q + 8'd1;
        res_final_q <= 12'(cell_q);
        if (all_in) begin
          res_status_q <= ST_INSIDE;
        end
      end
      S_NB: begin
        if (nb_end) begin
          res_status_q <= ST_LEFT;
        end else if (hop_q >= hl) begin
          res_status_q <= ST_HOPS;
        end else begin
          cell_q <= nb_rd[CW-1:0];
          vtx_q  <= 2'd0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      so_q <= res_status_q;
      fo_q <= res_final_q;
      ho_q <= hop_q;
      for (int i = 0; i < 4; i++) begin
        wo_q[i] <= w_q[i];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = so_q;
  assign final_cell_o = fo_q;
  assign weight_0_o   = wo_q[0];
  assign weight_1_o   = wo_q[1];
  assign weight_2_o   = wo_q[2];
  assign weight_3_o   = wo_q[3];
  assign hop_count_o  = ho_q;

  a_locate_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OP_LOCATE) |=> (state_q == S_START))
    else $error("locate item did not start a walk");

  a_hop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NB) |-> (hop_q != 8'd0 && hop_q <= hl))
    else $error("hop count outside limit during walk");

  a_quot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WSET) |-> !q_q[31])
    else $error("unsaturated quotient overflowed");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

endmodule

// File: src/tmpw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module tmpw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
